/* src/rti_pkg.sv */
// Shared types and constants for the ray/triangle intersection core.
// No dependencies; every other file imports this package.
`default_nettype none

package rti_pkg;

  localparam int COORD_BITS = 16;
  localparam int T_FRAC     = 16;
  localparam int VTX_BITS   = 3 * COORD_BITS;
  localparam int MDET_BITS  = 40;
  localparam int SUM_BITS   = 56;
  localparam int DET_BITS   = 54;
  localparam int DET_HALF   = DET_BITS / 2;
  localparam int Q_BITS     = 33;
  localparam int REM_BITS   = 88;

  typedef enum logic [1:0] {
    REG_VERTEX_A = 2'd0,
    REG_VERTEX_B = 2'd1,
    REG_VERTEX_C = 2'd2,
    REG_MIN_DET  = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic signed [15:0] origin_x;
    logic signed [15:0] origin_y;
    logic signed [15:0] origin_z;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
    logic signed [31:0] t_min;
    logic signed [31:0] t_max;
  } ray_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] hit_distance;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
  } result_t;

  typedef struct packed {
    logic signed [SUM_BITS-1:0] det;
    logic signed [SUM_BITS-1:0] u;
    logic signed [SUM_BITS-1:0] v;
    logic signed [SUM_BITS-1:0] tn;
    ray_t                       ray;
  } geom_t;

  typedef struct packed {
    logic                hit;
    logic                tneg;
    logic [DET_BITS-1:0] det;
    logic [REM_BITS-1:0] rem;
    logic [Q_BITS-1:0]   q;
    ray_t                ray;
  } div_t;

endpackage

`default_nettype wire

/* src/rti_geom.sv */
// Geometry stages: edges, the two cross products and the four dot products.
// Five register stages; depends on rti_pkg.
`default_nettype none

module rti_geom (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      adv,
  input  wire logic                      in_valid,
  input  wire rti_pkg::ray_t             ray,
  input  wire logic [rti_pkg::VTX_BITS-1:0] vertex_a,
  input  wire logic [rti_pkg::VTX_BITS-1:0] vertex_b,
  input  wire logic [rti_pkg::VTX_BITS-1:0] vertex_c,
  output logic                           out_valid,
  output rti_pkg::geom_t                 geom
);
  import rti_pkg::*;

  logic signed [15:0] va [3];
  logic signed [15:0] vb [3];
  logic signed [15:0] vc [3];
  logic signed [15:0] ro [3];

  logic               v1, v2, v3, v4, v5;
  ray_t               ray1, ray2, ray3, ray4;
  logic signed [16:0] e1_1 [3];
  logic signed [16:0] e2_1 [3];
  logic signed [16:0] s_1 [3];
  logic signed [16:0] e1_2 [3];
  logic signed [16:0] e2_2 [3];
  logic signed [16:0] s_2 [3];
  logic signed [16:0] e1_3 [3];
  logic signed [16:0] e2_3 [3];
  logic signed [16:0] s_3 [3];
  logic signed [33:0] pd [6];
  logic signed [34:0] qd [6];
  logic signed [34:0] p3 [3];
  logic signed [35:0] q3 [3];
  logic signed [SUM_BITS-1:0] det4 [3];
  logic signed [SUM_BITS-1:0] u4 [3];
  logic signed [SUM_BITS-1:0] v4p [3];
  logic signed [SUM_BITS-1:0] tn4 [3];
  logic signed [15:0] d2 [3];
  logic signed [15:0] d3 [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      va[i] = signed'(vertex_a[i*COORD_BITS +: COORD_BITS]);
      vb[i] = signed'(vertex_b[i*COORD_BITS +: COORD_BITS]);
      vc[i] = signed'(vertex_c[i*COORD_BITS +: COORD_BITS]);
    end
    ro[0] = ray.origin_x;
    ro[1] = ray.origin_y;
    ro[2] = ray.origin_z;
    d2[0] = ray1.dir_x;
    d2[1] = ray1.dir_y;
    d2[2] = ray1.dir_z;
    d3[0] = ray3.dir_x;
    d3[1] = ray3.dir_y;
    d3[2] = ray3.dir_z;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // stage 1: edges and origin offset
      ray1 <= ray;
      for (int i = 0; i < 3; i++) begin
        e1_1[i] <= 17'(vb[i]) - 17'(va[i]);
        e2_1[i] <= 17'(vc[i]) - 17'(va[i]);
        s_1[i]  <= 17'(ro[i]) - 17'(va[i]);
      end
      // stage 2: cross product terms, P = D x E2 and Q = S x E1
      ray2 <= ray1;
      e1_2 <= e1_1;
      e2_2 <= e2_1;
      s_2  <= s_1;
      pd[0] <= 34'(d2[1]) * 34'(e2_1[2]);
      pd[1] <= 34'(d2[2]) * 34'(e2_1[1]);
      pd[2] <= 34'(d2[2]) * 34'(e2_1[0]);
      pd[3] <= 34'(d2[0]) * 34'(e2_1[2]);
      pd[4] <= 34'(d2[0]) * 34'(e2_1[1]);
      pd[5] <= 34'(d2[1]) * 34'(e2_1[0]);
      qd[0] <= 35'(s_1[1]) * 35'(e1_1[2]);
      qd[1] <= 35'(s_1[2]) * 35'(e1_1[1]);
      qd[2] <= 35'(s_1[2]) * 35'(e1_1[0]);
      qd[3] <= 35'(s_1[0]) * 35'(e1_1[2]);
      qd[4] <= 35'(s_1[0]) * 35'(e1_1[1]);
      qd[5] <= 35'(s_1[1]) * 35'(e1_1[0]);
      // stage 3: cross product differences
      ray3 <= ray2;
      e1_3 <= e1_2;
      e2_3 <= e2_2;
      s_3  <= s_2;
      for (int i = 0; i < 3; i++) begin
        p3[i] <= 35'(pd[2*i]) - 35'(pd[2*i+1]);
        q3[i] <= 36'(qd[2*i]) - 36'(qd[2*i+1]);
      end
      // stage 4: dot product terms
      ray4 <= ray3;
      for (int i = 0; i < 3; i++) begin
        det4[i] <= SUM_BITS'(p3[i]) * SUM_BITS'(e1_3[i]);
        u4[i]   <= SUM_BITS'(p3[i]) * SUM_BITS'(s_3[i]);
        v4p[i]  <= SUM_BITS'(q3[i]) * SUM_BITS'(d3[i]);
        tn4[i]  <= SUM_BITS'(q3[i]) * SUM_BITS'(e2_3[i]);
      end
      // stage 5: sums
      geom.ray <= ray4;
      geom.det <= det4[0] + det4[1] + det4[2];
      geom.u   <= u4[0] + u4[1] + u4[2];
      geom.v   <= v4p[0] + v4p[1] + v4p[2];
      geom.tn  <= tn4[0] + tn4[1] + tn4[2];
    end
  end

  assign out_valid = v5;

endmodule

`default_nettype wire

/* src/rti_test.sv */
// Sign normalization and the division-free accept tests.
// Three register stages; depends on rti_pkg.
`default_nettype none

module rti_test (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         adv,
  input  wire logic                         in_valid,
  input  wire rti_pkg::geom_t               geom,
  input  wire logic [rti_pkg::MDET_BITS-1:0] min_det,
  output logic                              out_valid,
  output rti_pkg::div_t                     dv
);
  import rti_pkg::*;

  logic                       v6, v7, v8;
  logic [DET_BITS-1:0]        det6, det7;
  logic signed [SUM_BITS-1:0] u6, v6q, tn6, tn7;
  ray_t                       ray6, ray7;
  logic signed [59:0]         lo_min, hi_min, lo_max, hi_max;
  logic                       det_ok, uv_ok;
  logic signed [SUM_BITS:0]   uv_sum;
  logic signed [REM_BITS-1:0] ts, prod_min, prod_max;
  logic                       range_ok;

  assign uv_sum = (SUM_BITS+1)'(u6) + (SUM_BITS+1)'(v6q);

  always_comb begin
    ts       = REM_BITS'(tn7) <<< T_FRAC;
    prod_min = (REM_BITS'(hi_min) <<< DET_HALF) + REM_BITS'(lo_min);
    prod_max = (REM_BITS'(hi_max) <<< DET_HALF) + REM_BITS'(lo_max);
    range_ok = (ts >= prod_min) && (ts <= prod_max);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
      v7 <= 1'b0;
      v8 <= 1'b0;
    end else if (adv) begin
      v6 <= in_valid;
      v7 <= v6;
      v8 <= v7;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // stage 6: make det positive, flip the others with it
      ray6 <= geom.ray;
      if (geom.det[SUM_BITS-1]) begin
        det6 <= DET_BITS'(-geom.det);
        u6   <= -geom.u;
        v6q  <= -geom.v;
        tn6  <= -geom.tn;
      end else begin
        det6 <= DET_BITS'(geom.det);
        u6   <= geom.u;
        v6q  <= geom.v;
        tn6  <= geom.tn;
      end
      // stage 7: det times range bounds as two half products
      ray7   <= ray6;
      det7   <= det6;
      tn7    <= tn6;
      lo_min <= 60'($signed({1'b0, det6[DET_HALF-1:0]})) * 60'(ray6.t_min);
      hi_min <= 60'($signed({1'b0, det6[DET_BITS-1:DET_HALF]})) * 60'(ray6.t_min);
      lo_max <= 60'($signed({1'b0, det6[DET_HALF-1:0]})) * 60'(ray6.t_max);
      hi_max <= 60'($signed({1'b0, det6[DET_BITS-1:DET_HALF]})) * 60'(ray6.t_max);
      det_ok <= (det6 != '0) && (det6 >= DET_BITS'(min_det));
      uv_ok  <= !u6[SUM_BITS-1] && !v6q[SUM_BITS-1] &&
                (uv_sum <= $signed({3'b000, det6}));
      // stage 8: range test, seed the divider
      dv.ray  <= ray7;
      dv.det  <= det7;
      dv.hit  <= det_ok && uv_ok && range_ok;
      dv.tneg <= ts[REM_BITS-1];
      dv.rem  <= ts[REM_BITS-1] ? REM_BITS'(-ts) : ts;
      dv.q    <= '0;
    end
  end

  assign out_valid = v8;

endmodule

`default_nettype wire

/* src/rti_div.sv */
// Restoring divider, one quotient bit per register stage, for t = tn / det.
// Q_BITS stages; depends on rti_pkg.
`default_nettype none

module rti_div (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          adv,
  input  wire logic          in_valid,
  input  wire rti_pkg::div_t din,
  output logic               out_valid,
  output rti_pkg::div_t      dout
);
  import rti_pkg::*;

  div_t st  [Q_BITS+1];
  logic vld [Q_BITS+1];

  assign st[0]  = din;
  assign vld[0] = in_valid;

  for (genvar k = 0; k < Q_BITS; k++) begin : g_bit
    localparam int BIT = Q_BITS - 1 - k;
    logic [REM_BITS-1:0] dsh;
    div_t                nxt;

    always_comb begin
      dsh = REM_BITS'(st[k].det) << BIT;
      nxt = st[k];
      if (dsh <= st[k].rem) begin
        nxt.rem    = st[k].rem - dsh;
        nxt.q[BIT] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (adv) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        st[k+1] <= nxt;
      end
    end
  end

  assign out_valid = vld[Q_BITS];
  assign dout      = st[Q_BITS];

endmodule

`default_nettype wire

/* src/rti_point.sv */
// Hit point O + t*D with saturation, and the result register.
// Two register stages; depends on rti_pkg.
`default_nettype none

module rti_point (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            adv,
  input  wire logic            in_valid,
  input  wire rti_pkg::div_t   dv,
  output logic                 out_valid,
  output rti_pkg::result_t     res
);
  import rti_pkg::*;

  logic               va, vb;
  logic               hit_a, tneg_a;
  logic [Q_BITS-1:0]  q_a;
  logic signed [15:0] o_a [3];
  logic               dneg_a [3];
  logic [48:0]        m_a [3];
  logic signed [15:0] din [3];
  logic signed [15:0] oin [3];
  logic [15:0]        dmag [3];
  logic signed [34:0] p [3];
  logic signed [15:0] sat [3];

  always_comb begin
    din[0] = dv.ray.dir_x;
    din[1] = dv.ray.dir_y;
    din[2] = dv.ray.dir_z;
    oin[0] = dv.ray.origin_x;
    oin[1] = dv.ray.origin_y;
    oin[2] = dv.ray.origin_z;
    for (int i = 0; i < 3; i++) begin
      dmag[i] = din[i][15] ? 16'(-din[i]) : 16'(din[i]);
      p[i] = (tneg_a != dneg_a[i]) ?
             35'(o_a[i]) - 35'({2'b00, m_a[i][48:T_FRAC]}) :
             35'(o_a[i]) + 35'({2'b00, m_a[i][48:T_FRAC]});
      if (p[i] > 35'sd32767) begin
        sat[i] = 16'sh7fff;
      end else if (p[i] < -35'sd32768) begin
        sat[i] = 16'sh8000;
      end else begin
        sat[i] = 16'(p[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
    end else if (adv) begin
      va <= in_valid;
      vb <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hit_a  <= dv.hit;
      tneg_a <= dv.tneg;
      q_a    <= dv.q;
      for (int i = 0; i < 3; i++) begin
        o_a[i]    <= oin[i];
        dneg_a[i] <= din[i][15];
        m_a[i]    <= 49'(dv.q) * 49'(dmag[i]);
      end
      // drop everything but the hit flag on a miss
      res.hit <= hit_a;
      if (hit_a) begin
        res.hit_distance <= tneg_a ? 32'(-q_a) : q_a[31:0];
        res.pos_x <= sat[0];
        res.pos_y <= sat[1];
        res.pos_z <= sat[2];
      end else begin
        res.hit_distance <= '0;
        res.pos_x <= '0;
        res.pos_y <= '0;
        res.pos_z <= '0;
      end
    end
  end

  assign out_valid = vb;

endmodule

`default_nettype wire

/* src/ray_triangle_intersect_core.sv */
// Ray/triangle intersection core: configuration registers, pipeline control
// and the chain rti_geom, rti_test, rti_div, rti_point; depends on rti_pkg.
//
// Usage:
//   Load the three vertices and the minimum determinant through the write
//   port (cfg_wr_en, cfg_index, cfg_data) while no ray is in flight.
//   Rays enter on in_valid/in_stall with in_data; a transaction completes on
//   a clock edge with valid high and stall low. Each ray yields exactly one
//   result transaction on out_valid/out_stall with out_data.
//   The pipeline has 5 geometry stages, 3 test stages, 33 divider
//   stages (one quotient bit each) and 2 hit point stages, the last one
//   being the output register. Throughput is one ray per cycle unless
//   stalled. When the receiver stalls a valid result, the whole pipeline
//   holds and in_stall is raised in the same cycle; nothing is lost or
//   repeated. Reset (rst, synchronous) empties the pipeline and sets the
//   vertices to zero and the minimum determinant to one.
`default_nettype none

module ray_triangle_intersect_core (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire rti_pkg::ray_t    in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output rti_pkg::result_t      out_data,
  input  wire logic             cfg_wr_en,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [rti_pkg::VTX_BITS-1:0] cfg_data
);
  import rti_pkg::*;

  logic [VTX_BITS-1:0]  vertex_a, vertex_b, vertex_c;
  logic [MDET_BITS-1:0] min_det;
  logic                 adv;
  logic                 g_valid, t_valid, d_valid;
  geom_t                geom;
  div_t                 dv_t, dv_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_a <= '0;
      vertex_b <= '0;
      vertex_c <= '0;
      min_det  <= MDET_BITS'(1);
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_VERTEX_A: vertex_a <= cfg_data;
        REG_VERTEX_B: vertex_b <= cfg_data;
        REG_VERTEX_C: vertex_c <= cfg_data;
        REG_MIN_DET:  min_det  <= cfg_data[MDET_BITS-1:0];
        default:      ;
      endcase
    end
  end

  // advance all stages unless a finished result is held by the receiver
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  rti_geom u_geom (
    .clk, .rst, .adv,
    .in_valid  (in_valid),
    .ray       (in_data),
    .vertex_a, .vertex_b, .vertex_c,
    .out_valid (g_valid),
    .geom      (geom)
  );

  rti_test u_test (
    .clk, .rst, .adv,
    .in_valid  (g_valid),
    .geom      (geom),
    .min_det   (min_det),
    .out_valid (t_valid),
    .dv        (dv_t)
  );

  rti_div u_div (
    .clk, .rst, .adv,
    .in_valid  (t_valid),
    .din       (dv_t),
    .out_valid (d_valid),
    .dout      (dv_d)
  );

  rti_point u_point (
    .clk, .rst, .adv,
    .in_valid  (d_valid),
    .dv        (dv_d),
    .out_valid (out_valid),
    .res       (out_data)
  );

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.hit) |-> (out_data.hit_distance == '0 &&
      out_data.pos_x == '0 && out_data.pos_y == '0 && out_data.pos_z == '0))
    else $error("miss result carries nonzero fields");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid)
    else $error("stalled result dropped");

endmodule

`default_nettype wire

/* bench/rti_checker.sv */
// Scoreboard for the ray/triangle intersection core: mirrors the registers,
// predicts each ray's result and compares outgoing transactions. Uses rti_pkg.
module rti_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  rti_pkg::ray_t               in_data,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  rti_pkg::result_t            out_data,
  input  logic                        cfg_wr_en,
  input  logic [1:0]                  cfg_index,
  input  logic [rti_pkg::VTX_BITS-1:0] cfg_data,
  output int                          errors,
  output int                          pending
);
  import rti_pkg::*;

  logic [VTX_BITS-1:0]  vtx_a, vtx_b, vtx_c;
  logic [MDET_BITS-1:0] min_det;
  result_t              hits_due[$];

  initial errors = 0;
  assign pending = hits_due.size();

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic result_t trace_ray(ray_t r);
    longint a[3], b[3], c[3], o[3], d[3], e1[3], e2[3], s[3], p[3], q[3];
    logic signed [127:0] det, u, v, tn, ts, lo_b, hi_b;
    logic [127:0] mag;
    longint quo, m, off, pt;
    logic tneg;
    result_t res;
    res = '0;
    o[0] = longint'(r.origin_x); o[1] = longint'(r.origin_y); o[2] = longint'(r.origin_z);
    d[0] = longint'(r.dir_x);    d[1] = longint'(r.dir_y);    d[2] = longint'(r.dir_z);
    for (int i = 0; i < 3; i++) begin
      a[i] = longint'($signed(vtx_a[16*i +: 16]));
      b[i] = longint'($signed(vtx_b[16*i +: 16]));
      c[i] = longint'($signed(vtx_c[16*i +: 16]));
      e1[i] = b[i] - a[i];
      e2[i] = c[i] - a[i];
      s[i] = o[i] - a[i];
    end
    p[0] = d[1]*e2[2] - d[2]*e2[1];
    p[1] = d[2]*e2[0] - d[0]*e2[2];
    p[2] = d[0]*e2[1] - d[1]*e2[0];
    q[0] = s[1]*e1[2] - s[2]*e1[1];
    q[1] = s[2]*e1[0] - s[0]*e1[2];
    q[2] = s[0]*e1[1] - s[1]*e1[0];
    det = '0; u = '0; v = '0; tn = '0;
    for (int i = 0; i < 3; i++) begin
      det += 128'(p[i]) * 128'(e1[i]);
      u   += 128'(p[i]) * 128'(s[i]);
      v   += 128'(q[i]) * 128'(d[i]);
      tn  += 128'(q[i]) * 128'(e2[i]);
    end
    // normalize so the determinant is positive
    if (det < 0) begin
      det = -det; u = -u; v = -v; tn = -tn;
    end
    if (det == 0) return res;
    if (det < $signed({88'b0, min_det})) return res;
    ts = tn <<< T_FRAC;
    lo_b = det * 128'(r.t_min);
    hi_b = det * 128'(r.t_max);
    if (ts < lo_b || ts > hi_b) return res;
    if (u < 0 || v < 0 || u + v > det) return res;
    tneg = ts < 0;
    mag = tneg ? -ts : ts;
    quo = longint'(mag / det);
    res.hit = 1'b1;
    res.hit_distance = 32'(tneg ? -quo : quo);
    for (int i = 0; i < 3; i++) begin
      m = (quo * (d[i] < 0 ? -d[i] : d[i])) >>> T_FRAC;
      off = (tneg != (d[i] < 0)) ? -m : m;
      pt = o[i] + off;
      if (pt > 32767) pt = 32767;
      if (pt < -32768) pt = -32768;
      case (i)
        0: res.pos_x = 16'(pt);
        1: res.pos_y = 16'(pt);
        default: res.pos_z = 16'(pt);
      endcase
    end
    return res;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      vtx_a <= '0; vtx_b <= '0; vtx_c <= '0; min_det <= MDET_BITS'(1);
      hits_due.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_reg_t'(cfg_index))
          REG_VERTEX_A: vtx_a <= cfg_data;
          REG_VERTEX_B: vtx_b <= cfg_data;
          REG_VERTEX_C: vtx_c <= cfg_data;
          REG_MIN_DET:  min_det <= cfg_data[MDET_BITS-1:0];
        endcase
      end
      if (in_valid && !in_stall) hits_due.push_back(trace_ray(in_data));
      if (out_valid && !out_stall) begin
        if (hits_due.size() == 0) begin
          report("unexpected transaction", out_data.hit, 0);
        end else begin
          want = hits_due.pop_front();
          if (out_data.hit !== want.hit) report("hit", out_data.hit, want.hit);
          if (out_data.hit_distance !== want.hit_distance)
            report("hit_distance", out_data.hit_distance, want.hit_distance);
          if (out_data.pos_x !== want.pos_x) report("pos_x", out_data.pos_x, want.pos_x);
          if (out_data.pos_y !== want.pos_y) report("pos_y", out_data.pos_y, want.pos_y);
          if (out_data.pos_z !== want.pos_z) report("pos_z", out_data.pos_z, want.pos_z);
        end
      end
    end
  end
endmodule

/* bench/ray_triangle_intersect_core_tb.sv */
// Stimulus and verdict for the ray/triangle intersection core.
// Depends on rti_pkg, ray_triangle_intersect_core and rti_checker.
module ray_triangle_intersect_core_tb;
  import rti_pkg::*;

  localparam int LIMIT = 400000;

  logic clk = 0, rst = 1;
  logic in_valid = 0, out_stall = 1, cfg_wr_en = 0;
  logic in_stall, out_valid;
  ray_t in_data = '0;
  result_t out_data;
  logic [1:0] cfg_index = '0;
  logic [VTX_BITS-1:0] cfg_data = '0;
  int errors, pending, cycles = 0;
  int tx_idle = 0, rx_idle = 0, hold_reqs = 0, hold_seen = 0, hold_left = 0;
  longint va[3], vb[3], vc[3];

  always #5 clk = ~clk;

  ray_triangle_intersect_core DUT (
    .clk, .rst, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .cfg_wr_en, .cfg_index, .cfg_data
  );

  rti_checker u_checker (
    .clk, .rst, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .cfg_wr_en, .cfg_index, .cfg_data, .errors, .pending
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("** ray_triangle_intersect_core: FAILED **");
      $finish;
    end
  end

  // receiver: random stall, or a long hold-off when one is requested
  always @(negedge clk) begin
    if (hold_reqs != hold_seen) begin
      hold_seen = hold_reqs;
      hold_left = 300;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle);
    end
  end

  function automatic logic [VTX_BITS-1:0] pack(longint p[3]);
    return {p[2][15:0], p[1][15:0], p[0][15:0]};
  endfunction

  // write all registers back to back; the block must be empty
  task automatic load_triangle(logic [39:0] md);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_VERTEX_A; cfg_data <= pack(va);
    @(negedge clk);
    cfg_index <= REG_VERTEX_B; cfg_data <= pack(vb);
    @(negedge clk);
    cfg_index <= REG_VERTEX_C; cfg_data <= pack(vc);
    @(negedge clk);
    cfg_index <= REG_MIN_DET; cfg_data <= {8'b0, md};
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (50) @(negedge clk);
  endtask

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_ray(ray_t r);
    while ($urandom_range(99) < tx_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= r;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  function automatic ray_t mk(int ox, int oy, int oz, int dx, int dy, int dz,
                              int tlo, int thi);
    ray_t r;
    r.origin_x = 16'(ox); r.origin_y = 16'(oy); r.origin_z = 16'(oz);
    r.dir_x = 16'(dx); r.dir_y = 16'(dy); r.dir_z = 16'(dz);
    r.t_min = tlo; r.t_max = thi;
    return r;
  endfunction

  // aim at a random point of the triangle from a random distance
  function automatic ray_t aimed_ray();
    int wa, wb, k;
    longint tgt[3], dv[3];
    ray_t r;
    wa = $urandom_range(256);
    wb = $urandom_range(256 - wa);
    k = $urandom_range(1, 4);
    for (int i = 0; i < 3; i++) begin
      tgt[i] = va[i] + ((vb[i] - va[i]) * wa + (vc[i] - va[i]) * wb) / 256;
      dv[i] = longint'($signed(11'($urandom)));
    end
    r.dir_x = 16'(dv[0]); r.dir_y = 16'(dv[1]); r.dir_z = 16'(dv[2]);
    r.origin_x = 16'(tgt[0] - k * dv[0]);
    r.origin_y = 16'(tgt[1] - k * dv[1]);
    r.origin_z = 16'(tgt[2] - k * dv[2]);
    r.t_min = -int'($urandom_range(1 << 17));
    r.t_max = $urandom_range(3) == 0 ? int'($urandom_range(1 << 18)) : 32'h7fffffff;
    return r;
  endfunction

  function automatic longint rnd_coord(int span);
    return longint'($urandom_range(2 * span)) - span;
  endfunction

  initial begin
    logic [39:0] md;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // unit triangle in the z = 0 plane
    va = '{0, 0, 0}; vb = '{256, 0, 0}; vc = '{0, 256, 0};
    rx_idle = 84; tx_idle = 29;
    load_triangle(40'd1);
    send_ray(mk(64, 64, -256, 0, 0, 256, 0, 32'h7fffffff));      // center hit
    send_ray(mk(0, 64, -256, 0, 0, 256, 0, 32'h7fffffff));       // on an edge
    send_ray(mk(0, 0, -256, 0, 0, 256, 0, 32'h7fffffff));        // on a vertex
    send_ray(mk(128, 128, -256, 0, 0, 256, 0, 32'h7fffffff));    // u + v = det
    send_ray(mk(300, 10, -256, 0, 0, 256, 0, 32'h7fffffff));     // outside
    send_ray(mk(-1, 10, -256, 0, 0, 256, 0, 32'h7fffffff));      // negative u
    send_ray(mk(10, 10, -256, 256, 0, 0, 32'h80000000, 32'h7fffffff)); // parallel
    send_ray(mk(50, 50, 256, 0, 0, -256, 0, 32'h7fffffff));      // back side
    send_ray(mk(64, 64, -256, 0, 0, 256, 32'h10000, 32'h10000)); // t on both limits
    send_ray(mk(64, 64, -256, 0, 0, 256, 0, 32'hffff));          // just beyond t_max
    send_ray(mk(64, 64, -256, 0, 0, 256, 32'h10001, 32'h7fffffff)); // below t_min
    send_ray(mk(64, 64, -256, 0, 0, 256, 32'h20000, 32'h100));   // empty range
    send_ray(mk(64, 64, 256, 0, 0, 256, 32'h80000000, 32'h7fffffff)); // negative t
    send_ray(mk(32767, 32767, 32767, -32768, -32768, -32768,
                32'h80000000, 32'h7fffffff));
    send_ray(mk(-32768, -32768, -32768, 32767, 32767, 32767,
                32'h80000000, 32'h7fffffff));
    send_ray(mk(1, 1, -32768, 0, 0, 1, 0, 32'h7fffffff));       // long t
    drain();
    load_triangle(40'd0);
    send_ray(mk(10, 10, -256, 256, 0, 0, 32'h80000000, 32'h7fffffff)); // zero det
    send_ray(mk(64, 64, -256, 0, 0, 256, 0, 32'h7fffffff));
    drain();
    load_triangle(40'hff_ffff_ffff);
    send_ray(mk(64, 64, -256, 0, 0, 256, 0, 32'h7fffffff));      // below threshold
    drain();
    vc = '{256, 0, 0};                                           // degenerate
    load_triangle(40'd1);
    send_ray(mk(64, 0, -256, 0, 0, 256, 0, 32'h7fffffff));
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      tx_idle = ph < 2 ? 29 : ph < 4 ? 84 : 0;
      rx_idle = ph < 2 ? 84 : ph < 4 ? 29 : 0;
      for (int i = 0; i < 3; i++) begin
        case (ph)
          2, 3: begin
            va[i] = rnd_coord(32767); vb[i] = rnd_coord(32767); vc[i] = rnd_coord(32767);
          end
          default: begin
            va[i] = rnd_coord(1024); vb[i] = rnd_coord(1024); vc[i] = rnd_coord(1024);
          end
        endcase
      end
      if (ph == 5) vc = vb;
      case (ph)
        0: md = 40'd1;
        1: md = 40'($urandom_range(1 << 24));
        2: md = 40'd0;
        3: md = 40'hff_ffff_ffff;
        default: md = {8'($urandom), $urandom} >> $urandom_range(39);
      endcase
      load_triangle(md);
      for (int n = 0; n < 290; n++) begin
        if (ph == 4 && n == 100) hold_reqs++;
        if (ph == 5 && n == 150) begin
          in_valid <= 1'b0;
          wait (pending == 0);
          @(negedge clk);
        end
        if ($urandom_range(3) != 0) send_ray(aimed_ray());
        else send_ray(ray_t'({$urandom, $urandom, $urandom, $urandom, $urandom}));
      end
      drain();
    end

    if (errors == 0) begin
      $display("** ray_triangle_intersect_core: PASSED **");
    end else begin
      $display("** ray_triangle_intersect_core: FAILED **");
    end
    $finish;
  end
endmodule
